### rtl/core/csfa_pkg.sv
// ----------------------------------------------------------------------------
// csfa_pkg
// Shared sizes, codes and controller/datapath interface types of the
// contiguous slot fit allocator.
// ----------------------------------------------------------------------------
package csfa_pkg;

  // Road geometry
  localparam int unsigned ROAD_SLOTS = 80;
  localparam int unsigned POLICIES   = 4;

  // Field widths of the stream beats
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned SLOT_FLD_W  = 7;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 8;

  // Internal widths
  localparam int unsigned SLOT_W    = $clog2(ROAD_SLOTS);
  localparam int unsigned POS_W     = $clog2(ROAD_SLOTS + 128);
  localparam int unsigned CNT_W     = $clog2(ROAD_SLOTS + 2);
  localparam int unsigned MEM_DEPTH = POLICIES * ROAD_SLOTS;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [POS_W-1:0]  ROAD_POS   = POS_W'(ROAD_SLOTS);
  localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(ROAD_SLOTS - 1);
  localparam logic [CNT_W-1:0]  STEP_LIMIT = CNT_W'(ROAD_SLOTS);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MEM_DEPTH - 1);

  // Item kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } csfa_policy_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SEEK,
    ST_SCAN,
    ST_MARK,
    ST_POST
  } csfa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic seek_init;
    logic seek_step;
    logic scan_init;
    logic scan_step;
    logic mark_init;
    logic mark_step;
    logic post;
  } csfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic seek_done;
    logic scan_done;
    logic scan_found;
    logic mark_done;
    logic out_free;
    logic is_release;
    logic is_next;
    logic len_ok;
  } csfa_sts_t;

endpackage

### rtl/core/csfa_ram.sv
// ----------------------------------------------------------------------------
// csfa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module csfa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/csfa_datapath.sv
// ----------------------------------------------------------------------------
// csfa_datapath
// Item registers, occupancy RAM, serial fit scan, run marking and the
// result register.
// ----------------------------------------------------------------------------
module csfa_datapath import csfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csfa_cmd_t             cmd,
  output csfa_sts_t             sts,
  input  logic                  in_kind,
  input  logic [1:0]            in_policy,
  input  logic [LEN_W-1:0]      in_run_length,
  input  logic [SLOT_FLD_W-1:0] in_start_slot,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_granted,
  output logic [SLOT_FLD_W-1:0] out_slot
);

  // Item
  logic                  kind_r;
  csfa_policy_t          pol_r;
  logic [LEN_W-1:0]      len_r;
  logic [SLOT_FLD_W-1:0] start_r;
  logic [ADDR_W-1:0]     base_r;

  // Next fit start: start slot of the previous next fit grant
  logic [SLOT_W-1:0]     nf_start_r;
  logic [ADDR_W-1:0]     clr_ptr_r;

  // Read pipeline
  logic [POS_W-1:0]      iss_r;
  logic                  rd_vld_r;
  logic [POS_W-1:0]      rd_idx_r;
  logic                  rd_bit;

  // Seek and scan
  logic                  seek_fin_r;
  logic [SLOT_W-1:0]     j0_r;
  logic                  scan_fin_r;
  logic                  found_r;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      run_r;
  logic [CNT_W-1:0]      steps_r;
  logic [POS_W-1:0]      cur_start_r;
  logic [POS_W-1:0]      best_len_r;

  logic                  scan_fin_nxt;
  logic                  found_nxt;
  logic [POS_W-1:0]      pos_nxt;
  logic [POS_W-1:0]      run_nxt;
  logic [CNT_W-1:0]      steps_nxt;
  logic [POS_W-1:0]      cur_start_nxt;
  logic [POS_W-1:0]      best_len_nxt;

  // Marking
  logic [POS_W-1:0]      mpos_r;
  logic [LEN_W-1:0]      mrem_r;
  logic                  mark_done;

  // Result
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [SLOT_FLD_W-1:0] out_slot_r;

  logic [POS_W-1:0]      len_ext;
  logic [POS_W-1:0]      run_inc;
  logic [POS_W-1:0]      close_len;
  logic [POS_W-1:0]      fit_start;
  logic                  rd_free;
  logic                  is_last;
  logic                  is_virt;
  logic                  better;
  logic [SLOT_W-1:0]     rd_slot;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;

  assign len_ext   = POS_W'(len_r);
  assign run_inc   = run_r + 1'b1;
  assign is_virt   = (rd_idx_r == ROAD_POS);
  assign is_last   = (rd_idx_r == LAST_POS);
  assign rd_free   = !rd_bit && (rd_idx_r < ROAD_POS);
  assign close_len = rd_free ? run_inc : run_r;
  assign fit_start = rd_idx_r + 1'b1 - len_ext;
  assign mark_done = (mrem_r == '0) || (mpos_r >= ROAD_POS);

  // Memory ports
  assign rd_slot   = (iss_r < ROAD_POS) ? iss_r[SLOT_W-1:0] : '0;
  assign ram_raddr = base_r + ADDR_W'(rd_slot);
  assign ram_we    = cmd.clr_step || (cmd.mark_step && !mark_done);
  assign ram_waddr = cmd.clr_step ? clr_ptr_r : base_r + ADDR_W'(mpos_r[SLOT_W-1:0]);
  assign ram_wdata = cmd.clr_step ? 1'b0 : (kind_r == KIND_ALLOC);

  csfa_ram #(
    .WIDTH (1),
    .DEPTH (MEM_DEPTH)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_bit)
  );

  // Compare a closed run against the best one so far
  always_comb begin
    if (pol_r == POL_WORST) begin
      better = close_len > best_len_r;
    end else begin
      better = close_len < best_len_r;
    end
  end

  // One scan step on the slot whose read data just arrived
  always_comb begin
    scan_fin_nxt  = scan_fin_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    run_nxt       = run_r;
    steps_nxt     = steps_r;
    cur_start_nxt = cur_start_r;
    best_len_nxt  = best_len_r;
    if (rd_vld_r && !scan_fin_r) begin
      case (pol_r)
        POL_FIRST: begin
          run_nxt = rd_free ? run_inc : '0;
          if (rd_free && run_inc == len_ext) begin
            found_nxt    = 1'b1;
            pos_nxt      = fit_start;
            scan_fin_nxt = 1'b1;
          end else if (is_last) begin
            scan_fin_nxt = 1'b1;
          end
        end
        POL_NEXT: begin
          if (steps_r > STEP_LIMIT) begin
            scan_fin_nxt = 1'b1;
          end else if (!(is_virt && run_r == '0)) begin
            // The road end counts as a taken slot only after a free last slot
            steps_nxt = steps_r + 1'b1;
            run_nxt   = rd_free ? run_inc : '0;
            if (rd_free && run_inc == len_ext) begin
              found_nxt    = 1'b1;
              pos_nxt      = fit_start;
              scan_fin_nxt = 1'b1;
            end
          end
        end
        default: begin
          if (rd_free && run_r == '0) begin
            cur_start_nxt = rd_idx_r;
          end
          run_nxt = rd_free ? run_inc : '0;
          if ((!rd_free || is_last) && close_len >= len_ext && (!found_r || better)) begin
            found_nxt    = 1'b1;
            pos_nxt      = (rd_free && run_r == '0) ? rd_idx_r : cur_start_r;
            best_len_nxt = close_len;
          end
          if (is_last) begin
            scan_fin_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_start_r  <= '0;
      clr_ptr_r   <= '0;
      rd_vld_r    <= 1'b0;
      seek_fin_r  <= 1'b0;
      scan_fin_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end
      if (cmd.seek_init) begin
        rd_vld_r   <= 1'b0;
        seek_fin_r <= (nf_start_r == '0);
      end
      if (cmd.seek_step) begin
        rd_vld_r <= 1'b1;
        if (rd_vld_r && !seek_fin_r && (!rd_free || rd_idx_r == POS_W'(1))) begin
          seek_fin_r <= 1'b1;
        end
      end
      if (cmd.scan_init) begin
        rd_vld_r   <= 1'b0;
        scan_fin_r <= 1'b0;
        found_r    <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_vld_r   <= 1'b1;
        scan_fin_r <= scan_fin_nxt;
        found_r    <= found_nxt;
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
        if (kind_r == KIND_ALLOC && found_r && pol_r == POL_NEXT) begin
          nf_start_r <= pos_r[SLOT_W-1:0];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      pol_r   <= csfa_policy_t'(in_policy);
      len_r   <= in_run_length;
      start_r <= in_start_slot;
      base_r  <= ADDR_W'(in_policy) * ADDR_W'(ROAD_SLOTS);
    end
    if (cmd.seek_init) begin
      iss_r <= POS_W'(nf_start_r);
      j0_r  <= '0;
    end
    if (cmd.seek_step) begin
      // Walk down from the previous start; slot zero is never read
      if (iss_r > POS_W'(1)) begin
        iss_r <= iss_r - 1'b1;
      end
      rd_idx_r <= iss_r;
      if (rd_vld_r && !seek_fin_r && !rd_free) begin
        j0_r <= rd_idx_r[SLOT_W-1:0];
      end
    end
    if (cmd.scan_init) begin
      iss_r   <= (pol_r == POL_NEXT) ? POS_W'(j0_r) : '0;
      run_r   <= '0;
      steps_r <= '0;
    end
    if (cmd.scan_step) begin
      // Past the last slot comes the road end, then slot zero
      iss_r       <= (iss_r == ROAD_POS) ? '0 : iss_r + 1'b1;
      rd_idx_r    <= iss_r;
      pos_r       <= pos_nxt;
      run_r       <= run_nxt;
      steps_r     <= steps_nxt;
      cur_start_r <= cur_start_nxt;
      best_len_r  <= best_len_nxt;
    end
    if (cmd.mark_init) begin
      mpos_r <= (kind_r == KIND_RELEASE) ? POS_W'(start_r) : pos_r;
      mrem_r <= len_r;
    end
    if (cmd.mark_step && !mark_done) begin
      mpos_r <= mpos_r + 1'b1;
      mrem_r <= mrem_r - 1'b1;
    end
    if (cmd.post) begin
      out_granted_r <= (kind_r == KIND_RELEASE) || found_r;
      out_slot_r    <= (kind_r == KIND_ALLOC && found_r) ? pos_r[SLOT_FLD_W-1:0] : '0;
    end
  end

  assign sts.clr_last   = (clr_ptr_r == LAST_ADDR);
  assign sts.seek_done  = seek_fin_r;
  assign sts.scan_done  = scan_fin_r;
  assign sts.scan_found = found_r;
  assign sts.mark_done  = mark_done;
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.is_release = (kind_r == KIND_RELEASE);
  assign sts.is_next    = (pol_r == POL_NEXT);
  assign sts.len_ok     = (len_r != '0) && (len_ext <= ROAD_POS);

  assign out_tvalid  = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_slot    = out_slot_r;

endmodule

### rtl/core/csfa_ctrl.sv
// ----------------------------------------------------------------------------
// csfa_ctrl
// Sequencer: clearing pass, item intake, seek, scan, marking and result post.
// ----------------------------------------------------------------------------
module csfa_ctrl import csfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  csfa_sts_t sts,
  output csfa_cmd_t cmd
);

  csfa_state_t state_r;
  csfa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_release) begin
          cmd.mark_init = 1'b1;
          state_nxt     = ST_MARK;
        end else if (!sts.len_ok) begin
          state_nxt = ST_POST;
        end else if (sts.is_next) begin
          cmd.seek_init = 1'b1;
          state_nxt     = ST_SEEK;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SEEK: begin
        if (sts.seek_done) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else begin
          cmd.seek_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          if (sts.scan_found) begin
            cmd.mark_init = 1'b1;
            state_nxt     = ST_MARK;
          end else begin
            state_nxt = ST_POST;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MARK: begin
        if (sts.mark_done) begin
          state_nxt = ST_POST;
        end else begin
          cmd.mark_step = 1'b1;
        end
      end
      ST_POST: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/contiguous_slot_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// contiguous_slot_fit_allocator_unit
// Throughput: one item at a time, paced by the serial slot scan (one slot/cycle).
// Reset: synchronous; a clearing pass writes all POLICIES * ROAD_SLOTS (320)
// slots free while in_tready stays low.
// ----------------------------------------------------------------------------
module contiguous_slot_fit_allocator_unit import csfa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // run_length[6:0], start_slot[13:7], pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[0], policy[2:1]
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot[6:0], pad
  output logic                   out_tuser   // granted
);

  csfa_cmd_t cmd;
  csfa_sts_t sts;

  logic                  in_kind;
  logic [1:0]            in_policy;
  logic [LEN_W-1:0]      in_run_length;
  logic [SLOT_FLD_W-1:0] in_start_slot;
  logic                  out_granted;
  logic [SLOT_FLD_W-1:0] out_slot;

  // Unpack the input beat
  assign in_kind       = in_tuser[0];
  assign in_policy     = in_tuser[2:1];
  assign in_run_length = in_tdata[LEN_W-1:0];
  assign in_start_slot = in_tdata[LEN_W+SLOT_FLD_W-1:LEN_W];

  // Sequencer: owns the handshake on the input side and steps the datapath
  csfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: occupancy RAM, scan, marking and the result register, which
  // holds a finished beat while the next item is already taken in
  csfa_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_policy     (in_policy),
    .in_run_length (in_run_length),
    .in_start_slot (in_start_slot),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_granted   (out_granted),
    .out_slot      (out_slot)
  );

  // Pack the result beat
  assign out_tdata = {{(OUT_TDATA_W-SLOT_FLD_W){1'b0}}, out_slot};
  assign out_tuser = out_granted;

`ifndef ASSERT_OFF
  // The sequencer drives at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clr_step, cmd.seek_init, cmd.seek_step, cmd.scan_init,
              cmd.scan_step, cmd.mark_init, cmd.mark_step, cmd.post}))
    else $error("more than one datapath command in a cycle");

  // A result is posted only when the output register is free
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_tvalid || out_tready))
    else $error("result posted over a pending beat");

  // A posted result shows up on the output in the next cycle
  a_post_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |=> out_tvalid)
    else $error("posted result not presented");

  // Accepting a beat closes the input until the item is finished
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after accept");
`endif

endmodule
